// ===== hw/rtl/ntc_lookup_and_sensor_fusion_core_macros.svh =====
// ----------------------------------------------------------------------------
// ntc lookup and sensor fusion core - assertion macros
// shared concurrent assertion forms, clocked on clock, held off during reset
// ----------------------------------------------------------------------------
`ifndef NTC_LOOKUP_AND_SENSOR_FUSION_CORE_MACROS_SVH
`define NTC_LOOKUP_AND_SENSOR_FUSION_CORE_MACROS_SVH

// same-cycle implication
`define NTCLSF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NTCLSF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ntclsf_pkg.sv =====
// ----------------------------------------------------------------------------
// ntclsf_pkg
// types, constants and the thermistor resistance table of the fusion core
// ----------------------------------------------------------------------------
package ntclsf_pkg;

   localparam int TABLE_ENTRIES_DEF  = 106;
   localparam int ADC_FULL_SCALE_DEF = 4096;
   localparam int ROWS_STORED        = 106;

   localparam int ADC_W     = 12;
   localparam int DATA_W    = 16;
   localparam int RES_W     = 12;
   localparam int FRAC_W    = 8;
   localparam int CSR_IDX_W = 8;
   // widest dividend of the resistance division: 3299 * 1000
   localparam int DIV_MIN_W = 22;

   localparam int MV_NUM    = 3300000;
   localparam int MV_DEN    = 1000;
   localparam int SUPPLY_MV = 3300;

   // fusion constants in q8.8
   localparam int NTC_BIAS = 422;
   localparam int HALF_ADJ = 64;
   localparam int THR_AVG  = 281;
   localparam int THR_HALF = 128;
   localparam int THR_045  = 115;
   localparam int THR_025  = 64;

   localparam int              CAL_ROUND  = 2048;
   localparam int              CAL_SHIFT  = 12;
   localparam logic [DATA_W-1:0] GAIN_RESET = 16'h1000;
   localparam int              TEMP_MAX   = 32767;
   localparam int              TEMP_MIN   = -32768;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_GAIN   = 8'd0,
      CSR_CAL_OFFSET = 8'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_DIV_END,
      S_RD0,
      S_RD1,
      S_WALK,
      S_FUSE,
      S_MUL,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      TAG_MV,
      TAG_RES,
      TAG_FRAC
   } div_tag_type;

   // divider resistance in 10 ohm units, row index is degrees
   localparam logic [RES_W-1:0] RES_TABLE [ROWS_STORED] = '{
      12'd3274, 12'd3111, 12'd2957, 12'd2812, 12'd2674, 12'd2545, 12'd2422, 12'd2306,
      12'd2196, 12'd2092, 12'd1993, 12'd1900, 12'd1811, 12'd1728, 12'd1648, 12'd1573,
      12'd1501, 12'd1433, 12'd1369, 12'd1308, 12'd1250, 12'd1194, 12'd1142, 12'd1092,
      12'd1045, 12'd1000, 12'd957,  12'd916,  12'd877,  12'd840,  12'd805,  12'd771,
      12'd739,  12'd709,  12'd679,  12'd652,  12'd625,  12'd600,  12'd576,  12'd553,
      12'd531,  12'd510,  12'd490,  12'd471,  12'd453,  12'd435,  12'd418,  12'd402,
      12'd387,  12'd372,  12'd358,  12'd345,  12'd332,  12'd320,  12'd308,  12'd297,
      12'd286,  12'd276,  12'd266,  12'd256,  12'd247,  12'd238,  12'd230,  12'd222,
      12'd214,  12'd207,  12'd199,  12'd193,  12'd186,  12'd180,  12'd174,  12'd168,
      12'd162,  12'd157,  12'd152,  12'd147,  12'd142,  12'd137,  12'd133,  12'd128,
      12'd124,  12'd120,  12'd116,  12'd113,  12'd109,  12'd106,  12'd102,  12'd99,
      12'd96,   12'd93,   12'd90,   12'd88,   12'd85,   12'd82,   12'd80,   12'd78,
      12'd75,   12'd73,   12'd71,   12'd69,   12'd67,   12'd65,   12'd63,   12'd61,
      12'd59,   12'd58
   };

endpackage

// ===== hw/rtl/ntc_lookup_and_sensor_fusion_core.sv =====
// ----------------------------------------------------------------------------
// ntc_lookup_and_sensor_fusion_core
// thermistor table lookup fused with a digital sensor reading, calibrated
// ----------------------------------------------------------------------------
// flow: millivolts by reciprocal multiply and a check against the supply, then a
//   resistance division, the table walk, a fraction division, fusion and calibration;
//   millivolts at or above the supply skip to fusion, as does a walk with no bracket
// throughput: one item at a time, next item taken the cycle after the result
//   is loaded; set by the shared bit-serial divider and the table walk
// reset: synchronous active high; gain 1.0, offset 0, last source digital
// ----------------------------------------------------------------------------
`include "ntc_lookup_and_sensor_fusion_core_macros.svh"

module ntc_lookup_and_sensor_fusion_core
   import ntclsf_pkg::*;
#(
   parameter int TABLE_ENTRIES  = TABLE_ENTRIES_DEF,
   parameter int ADC_FULL_SCALE = ADC_FULL_SCALE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input item channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_W-1:0]     req_digital_raw,
   input  logic [ADC_W-1:0]      req_adc_sample,
   // result item channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [DATA_W-1:0] rsp_temperature,
   output logic                  rsp_source_is_ntc,
   output logic                  rsp_ntc_in_table,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DATA_W-1:0]     csr_wdata
);

   // table rows actually walked
   localparam int ROWS     = (TABLE_ENTRIES < ROWS_STORED) ? TABLE_ENTRIES : ROWS_STORED;
   localparam int IDX_W    = $clog2(ROWS);
   // millivolt scale, worked out at elaboration
   localparam int MV_SCALE = MV_NUM / ADC_FULL_SCALE;
   localparam int ADC_MAX  = (1 << ADC_W) - 1;
   localparam int PROD_W   = $clog2(MV_SCALE * ADC_MAX + 1);
   // millivolts by reciprocal multiply, exact for products below 2**PROD_W
   localparam int     RCP_SHIFT = PROD_W + $clog2(MV_DEN);
   localparam longint RCP_MUL   =
      ((longint'(1) <<< RCP_SHIFT) + longint'(MV_DEN) - 1) / longint'(MV_DEN);
   localparam longint MV_MUL    = RCP_MUL * longint'(MV_SCALE);
   localparam int     MV_MUL_W  = $clog2(MV_MUL + 1);
   localparam int     MV_PROD_W = ADC_W + MV_MUL_W;
   // divider width covers the resistance dividend
   localparam int DIV_W    = DIV_MIN_W;
   localparam int CNT_W    = $clog2(DIV_W);
   localparam int LK_W     = IDX_W + FRAC_W;
   localparam int NTC_W    = LK_W + 1;
   localparam int FUSE_W   = DATA_W + 2;
   localparam int MUL_W    = FUSE_W + DATA_W;
   localparam int SUM_W    = MUL_W - CAL_SHIFT + 1;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(TEMP_MAX);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(TEMP_MIN);

   // control
   state_type                 state_ff, state_in;
   div_tag_type               tag_ff, tag_in;
   logic                      last_source_ff, last_source_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]         gain_ff, offset_ff;

   // datapath
   logic [DATA_W-1:0]         dig_ff, dig_in;
   logic [DIV_W-1:0]          num_ff, num_in;
   logic [RES_W-1:0]          rem_ff, rem_in;
   logic [RES_W-1:0]          den_ff, den_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [DIV_W-1:0]          r_ff, r_in;
   logic [RES_W-1:0]          hi_ff, hi_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [LK_W-1:0]           lookup_ff, lookup_in;
   logic                      hit_ff, hit_in;
   logic signed [FUSE_W-1:0]  fused_ff, fused_in;
   logic signed [MUL_W-1:0]   mul_ff, mul_in;
   logic [RES_W-1:0]          rom_data_ff;
   logic signed [DATA_W-1:0]  rsp_temp_ff, rsp_temp_in;
   logic                      rsp_src_ff, rsp_src_in;
   logic                      rsp_hit_ff, rsp_hit_in;

   // combinational helpers
   logic                      req_fire;
   logic                      out_free;
   logic [MV_PROD_W-1:0]      mv_prod;
   logic [RES_W:0]            div_trial;
   logic [RES_W:0]            div_diff;
   logic                      div_ge;
   logic [IDX_W:0]            rom_addr_raw;
   logic [IDX_W-1:0]          rom_addr;
   logic                      in_bracket;
   logic                      walk_last;
   logic                      mv_over;
   logic [RES_W-1:0]          mv;
   logic [NTC_W-1:0]          ntc;
   logic signed [FUSE_W-1:0]  dig_s, ntc_s, d_up, d_dn, avg_s;
   logic signed [MUL_W-1:0]   rnd_s;
   logic signed [SUM_W-1:0]   sum_s;
   logic signed [DATA_W-1:0]  sat_s;

   assign req_stall         = (state_ff != S_IDLE);
   assign req_fire          = req_valid && !req_stall;
   assign out_free          = !rsp_valid_ff || !rsp_stall;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_temperature   = rsp_temp_ff;
   assign rsp_source_is_ntc = rsp_src_ff;
   assign rsp_ntc_in_table  = rsp_hit_ff;

   // adc times scale times the reciprocal of 1000, quotient in the top bits
   assign mv_prod = MV_PROD_W'(req_adc_sample) * MV_PROD_W'(MV_MUL);

   // one restoring step of the shared divider
   assign div_trial = {rem_ff, num_ff[DIV_W-1]};
   assign div_diff  = div_trial - {1'b0, den_ff};
   assign div_ge    = (div_trial >= {1'b0, den_ff});

   // millivolt check on the first quotient
   assign mv_over = (num_ff >= DIV_W'(SUPPLY_MV));
   assign mv      = num_ff[RES_W-1:0];

   // table walk: hi_ff is row idx, rom_data_ff is row idx+1
   assign in_bracket = (r_ff <= DIV_W'(hi_ff)) && (r_ff > DIV_W'(rom_data_ff));
   assign walk_last  = (idx_ff == IDX_W'(ROWS - 2));

   always_comb begin
      case (state_ff)
         S_RD1:   rom_addr_raw = (IDX_W + 1)'(1);
         S_WALK:  rom_addr_raw = {1'b0, idx_ff} + (IDX_W + 1)'(2);
         default: rom_addr_raw = '0;
      endcase
   end

   // addresses past the last row are never used, park them on row zero
   assign rom_addr = (rom_addr_raw < (IDX_W + 1)'(ROWS)) ? rom_addr_raw[IDX_W-1:0] : '0;

   // table rom, registered read
   always_ff @(posedge clock) begin
      rom_data_ff <= RES_TABLE[rom_addr];
   end

   // fusion arithmetic, all readings non-negative
   assign ntc   = NTC_W'(lookup_ff) + NTC_W'(NTC_BIAS);
   assign dig_s = signed'(FUSE_W'(dig_ff));
   assign ntc_s = signed'(FUSE_W'(ntc));
   assign d_up  = ntc_s - dig_s;
   assign d_dn  = dig_s - ntc_s;
   assign avg_s = (dig_s + ntc_s) >>> 1;

   // calibration: round to nearest, ties up, then offset and saturate
   assign rnd_s = (mul_ff + signed'(MUL_W'(CAL_ROUND))) >>> CAL_SHIFT;
   assign sum_s = SUM_W'(rnd_s) + SUM_W'(signed'(offset_ff));

   always_comb begin
      if (sum_s > SAT_HI) begin
         sat_s = DATA_W'(TEMP_MAX);
      end else if (sum_s < SAT_LO) begin
         sat_s = DATA_W'(TEMP_MIN);
      end else begin
         sat_s = sum_s[DATA_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_DIV_END;
         end
         S_DIV: begin
            if (cnt_ff == '0) state_in = S_DIV_END;
         end
         S_DIV_END: begin
            case (tag_ff)
               TAG_MV:   state_in = mv_over ? S_FUSE : S_DIV;
               TAG_RES:  state_in = S_RD0;
               TAG_FRAC: state_in = S_FUSE;
               default:  state_in = S_FUSE;
            endcase
         end
         S_RD0:  state_in = S_RD1;
         S_RD1:  state_in = S_WALK;
         S_WALK: begin
            if (in_bracket) begin
               state_in = S_DIV;
            end else if (walk_last) begin
               state_in = S_FUSE;
            end
         end
         S_FUSE: state_in = S_MUL;
         S_MUL:  state_in = S_DONE;
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      dig_in         = dig_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      den_in         = den_ff;
      cnt_in         = cnt_ff;
      tag_in         = tag_ff;
      r_in           = r_ff;
      hi_in          = hi_ff;
      idx_in         = idx_ff;
      lookup_in      = lookup_ff;
      hit_in         = hit_ff;
      fused_in       = fused_ff;
      mul_in         = mul_ff;
      last_source_in = last_source_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_temp_in    = rsp_temp_ff;
      rsp_src_in     = rsp_src_ff;
      rsp_hit_in     = rsp_hit_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // millivolts = scale * adc / 1000, by reciprocal multiply
               dig_in    = req_digital_raw;
               num_in    = DIV_W'(mv_prod[MV_PROD_W-1:RCP_SHIFT]);
               tag_in    = TAG_MV;
               hit_in    = 1'b0;
               lookup_in = '0;
            end
         end
         S_DIV: begin
            rem_in = div_ge ? div_diff[RES_W-1:0] : div_trial[RES_W-1:0];
            num_in = {num_ff[DIV_W-2:0], div_ge};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         S_DIV_END: begin
            case (tag_ff)
               TAG_MV: begin
                  if (!mv_over) begin
                     // resistance = mv * 1000 / (3300 - mv)
                     num_in = DIV_W'(mv) * DIV_W'(MV_DEN);
                     den_in = RES_W'(SUPPLY_MV) - mv;
                     rem_in = '0;
                     cnt_in = CNT_W'(DIV_W - 1);
                     tag_in = TAG_RES;
                  end
               end
               TAG_RES: begin
                  r_in   = num_ff;
                  idx_in = '0;
               end
               TAG_FRAC: begin
                  lookup_in = {idx_ff, num_ff[FRAC_W-1:0]};
                  hit_in    = 1'b1;
               end
               default: begin
                  hit_in = 1'b0;
               end
            endcase
         end
         S_RD0: begin
            idx_in = '0;
         end
         S_RD1: begin
            hi_in = rom_data_ff;
         end
         S_WALK: begin
            if (in_bracket) begin
               // fraction = 256 * (hi - r) / (hi - lo), r fits the row width here
               num_in = DIV_W'({hi_ff - r_ff[RES_W-1:0], {FRAC_W{1'b0}}});
               den_in = hi_ff - rom_data_ff;
               rem_in = '0;
               cnt_in = CNT_W'(DIV_W - 1);
               tag_in = TAG_FRAC;
            end else if (!walk_last) begin
               idx_in = idx_ff + IDX_W'(1);
               hi_in  = rom_data_ff;
            end
         end
         S_FUSE: begin
            if (d_up > 0) begin
               if (d_up > FUSE_W'(THR_AVG)) begin
                  // far above: average, source kept
                  fused_in = avg_s;
               end else if (d_up > FUSE_W'(THR_HALF)) begin
                  fused_in       = ntc_s;
                  last_source_in = 1'b1;
               end else begin
                  fused_in       = dig_s;
                  last_source_in = 1'b0;
               end
            end else if (d_dn > 0) begin
               if (d_dn > FUSE_W'(THR_HALF)) begin
                  fused_in       = ntc_s;
                  last_source_in = 1'b1;
               end else if ((d_dn > FUSE_W'(THR_045)) && (d_dn < FUSE_W'(THR_HALF))) begin
                  fused_in       = ntc_s + FUSE_W'(HALF_ADJ);
                  last_source_in = 1'b1;
               end else if ((d_dn > FUSE_W'(THR_025)) && (d_dn <= FUSE_W'(THR_045))) begin
                  fused_in       = dig_s - FUSE_W'(HALF_ADJ);
                  last_source_in = 1'b0;
               end else begin
                  // small gap, or exactly half a degree below
                  fused_in       = dig_s;
                  last_source_in = 1'b0;
               end
            end else begin
               fused_in       = dig_s;
               last_source_in = 1'b0;
            end
         end
         S_MUL: begin
            mul_in = fused_ff * signed'(gain_ff);
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_temp_in  = sat_s;
               rsp_src_in   = last_source_ff;
               rsp_hit_in   = hit_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         last_source_ff <= 1'b0;
         gain_ff        <= GAIN_RESET;
         offset_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         last_source_ff <= last_source_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CAL_GAIN) begin
               gain_ff <= csr_wdata;
            end else if (csr_index == CSR_CAL_OFFSET) begin
               offset_ff <= csr_wdata;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dig_ff      <= dig_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      cnt_ff      <= cnt_in;
      tag_ff      <= tag_in;
      r_ff        <= r_in;
      hi_ff       <= hi_in;
      idx_ff      <= idx_in;
      lookup_ff   <= lookup_in;
      hit_ff      <= hit_in;
      fused_ff    <= fused_in;
      mul_ff      <= mul_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_src_ff  <= rsp_src_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   // checks
   `NTCLSF_ASSERT_NEXT(a_accept_starts_mv, req_fire, (state_ff == S_DIV_END) && (tag_ff == TAG_MV), "no mv check")
   `NTCLSF_ASSERT_NEXT(a_div_ends, (state_ff == S_DIV) && (cnt_ff == '0), state_ff == S_DIV_END, "divider overran its step count")
   `NTCLSF_ASSERT_IMP(a_frac_narrow, (state_ff == S_DIV_END) && (tag_ff == TAG_FRAC), num_ff[DIV_W-1:FRAC_W] == '0, "interpolation fraction wider than eight bits")
   `NTCLSF_ASSERT_IMP(a_walk_in_range, state_ff == S_WALK, idx_ff <= IDX_W'(ROWS - 2), "table walk past last bracket")
   `NTCLSF_ASSERT_NEXT(a_result_loaded, (state_ff == S_DONE) && out_free, rsp_valid_ff && (state_ff == S_IDLE), "result not loaded on completion")

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb - ntc lookup and sensor fusion core testbench
// drives digital sensor and thermistor adc item pairs, predicts the calibrated
// fused temperature and compares every result item field by field
// ----------------------------------------------------------------------------
module tb
   import ntclsf_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // run shape
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int DRAIN_CYCLES     = 200;
   localparam int SETTLE_CYCLES    = 8;
   localparam int NUM_PHASES       = 8;
   localparam int RANDOM_PER_PHASE = 219;

   // thermistor conversion, resistance in 10 ohm units
   localparam int  NTC_ROWS       = 106;
   localparam longint MV_PER_CODE = 3300000 / 4096;
   localparam longint SUPPLY_MVOLT = 3300;
   // adc codes that land inside the table, roughly
   localparam int  ADC_HIT_LO     = 220;
   localparam int  ADC_HIT_HI     = 3150;
   localparam int  MID_ADC        = 1400;

   // fusion thresholds in q8.8 degrees
   localparam longint NTC_OFFSET  = 422;
   localparam longint QUARTER_ADJ = 64;
   localparam longint LIM_AVERAGE = 281;
   localparam longint LIM_HALF    = 128;
   localparam longint LIM_045     = 115;
   localparam longint LIM_025     = 64;
   localparam longint GAIN_HALF   = 2048;
   localparam int     GAIN_BITS   = 12;

   typedef struct {
      logic [DATA_W-1:0] digital_raw;
      logic [ADC_W-1:0]  adc_sample;
   } sample_type;

   typedef struct {
      logic signed [DATA_W-1:0] temperature;
      logic                     source_is_ntc;
      logic                     ntc_in_table;
   } reading_type;

   // resistance table, row index is degrees celsius
   int therm_res [0:NTC_ROWS-1] = '{
      3274, 3111, 2957, 2812, 2674, 2545, 2422, 2306, 2196, 2092,
      1993, 1900, 1811, 1728, 1648, 1573, 1501, 1433, 1369, 1308,
      1250, 1194, 1142, 1092, 1045, 1000, 957, 916, 877, 840,
      805, 771, 739, 709, 679, 652, 625, 600, 576, 553,
      531, 510, 490, 471, 453, 435, 418, 402, 387, 372,
      358, 345, 332, 320, 308, 297, 286, 276, 266, 256,
      247, 238, 230, 222, 214, 207, 199, 193, 186, 180,
      174, 168, 162, 157, 152, 147, 142, 137, 133, 128,
      124, 120, 116, 113, 109, 106, 102, 99, 96, 93,
      90, 88, 85, 82, 80, 78, 75, 73, 71, 69,
      67, 65, 63, 61, 59, 58
   };

   // differences (ntc minus digital) that sit on the fusion thresholds
   int fusion_edges [0:17] = '{
      282, 281, 280, 129, 128, 127, 1, 0, -1,
      -63, -64, -65, -114, -115, -116, -127, -128, -129
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [DATA_W-1:0]        req_digital_raw = '0;
   logic [ADC_W-1:0]         req_adc_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_temperature;
   logic                     rsp_source_is_ntc;
   logic                     rsp_ntc_in_table;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [DATA_W-1:0]        csr_wdata = '0;

   // predictor state and register copies
   logic                     ntc_chosen = 1'b0;
   logic signed [DATA_W-1:0] gain_q412 = 16'sh1000;
   logic signed [DATA_W-1:0] offset_q88 = '0;

   sample_type  pending_samples [$];
   reading_type expected_readings [$];
   sample_type  head_sample;
   reading_type want;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int items_accepted = 0;
   int readings_checked = 0;
   int failures = 0;
   int idle_cycles = 0;

   ntc_lookup_and_sensor_fusion_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_digital_raw   (req_digital_raw),
      .req_adc_sample    (req_adc_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_temperature   (rsp_temperature),
      .rsp_source_is_ntc (rsp_source_is_ntc),
      .rsp_ntc_in_table  (rsp_ntc_in_table),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // thermistor reading in q8.8 without the offset; hit set on a bracket
   function automatic longint thermistor_q8(input logic [ADC_W-1:0] adc, output logic hit);
      longint mv;
      longint res;
      longint hi;
      longint lo;
      longint reading;
      hit = 1'b0;
      reading = 0;
      mv = (MV_PER_CODE * longint'(adc)) / 1000;
      // divider at or above the supply counts as off the table
      if (mv < SUPPLY_MVOLT) begin
         res = (mv * 1000) / (SUPPLY_MVOLT - mv);
         // first bracket wins, last row is never a top
         for (int i = 0; i + 1 < NTC_ROWS && !hit; i++) begin
            hi = therm_res[i];
            lo = therm_res[i+1];
            if (res <= hi && res > lo) begin
               hit = 1'b1;
               reading = 256 * i + ((hi - res) * 256) / (hi - lo);
            end
         end
      end
      return reading;
   endfunction

   // fused, calibrated temperature for one item; moves the source state on
   function automatic reading_type fuse_reading(input logic [DATA_W-1:0] dig_raw,
                                                input logic [ADC_W-1:0] adc);
      reading_type r;
      logic     hit;
      longint   dig;
      longint   ntc;
      longint   d;
      longint   fused;
      longint   t;
      dig = longint'(dig_raw);
      ntc = thermistor_q8(adc, hit) + NTC_OFFSET;
      if (ntc > dig) begin
         d = ntc - dig;
         if (d > LIM_AVERAGE) begin
            // far above: average, source left as it was
            fused = (dig + ntc) / 2;
         end else if (d > LIM_HALF) begin
            fused = ntc;
            ntc_chosen = 1'b1;
         end else begin
            fused = dig;
            ntc_chosen = 1'b0;
         end
      end else if (ntc < dig) begin
         d = dig - ntc;
         if (d > LIM_HALF) begin
            fused = ntc;
            ntc_chosen = 1'b1;
         end else if (d > LIM_045 && d < LIM_HALF) begin
            fused = ntc + QUARTER_ADJ;
            ntc_chosen = 1'b1;
         end else if (d > LIM_025 && d <= LIM_045) begin
            fused = dig - QUARTER_ADJ;
            ntc_chosen = 1'b0;
         end else begin
            // includes exactly half a degree below
            fused = dig;
            ntc_chosen = 1'b0;
         end
      end else begin
         fused = dig;
         ntc_chosen = 1'b0;
      end
      // round half up, then saturate
      t = ((fused * longint'(gain_q412) + GAIN_HALF) >>> GAIN_BITS) + longint'(offset_q88);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      r.temperature   = t[DATA_W-1:0];
      r.source_is_ntc = ntc_chosen;
      r.ntc_in_table  = hit;
      return r;
   endfunction

   task automatic add_sample(input int dig, input int adc);
      sample_type s;
      s.digital_raw = dig[DATA_W-1:0];
      s.adc_sample  = adc[ADC_W-1:0];
      pending_samples.push_back(s);
   endtask

   // digital reading placed delta below the offset thermistor reading
   task automatic add_near(input int adc, input int delta);
      logic   hit;
      longint base;
      base = thermistor_q8(adc[ADC_W-1:0], hit) + NTC_OFFSET;
      add_sample(int'(base) - delta, adc);
   endtask

   task automatic add_random_samples(input int count);
      int adc;
      for (int k = 0; k < count; k++) begin
         // mostly adc codes inside the table
         if ($urandom_range(99) < 70) adc = $urandom_range(ADC_HIT_HI, ADC_HIT_LO);
         else adc = $urandom_range(4095);
         // mostly digital readings close to the thermistor, some anywhere
         if ($urandom_range(99) < 65) begin
            if ($urandom_range(1) == 1) add_near(adc, fusion_edges[$urandom_range(17)]);
            else add_near(adc, int'($urandom_range(800)) - 400);
         end else begin
            add_sample($urandom_range(65535), adc);
         end
      end
   endtask

   // register write, only issued with the core idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_CAL_GAIN) gain_q412 = value;
      else if (idx == CSR_CAL_OFFSET) offset_q88 = value;
      csr_valid <= 1'b0;
   endtask

   // all items sent, all results back, then a short settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_readings.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // item driver: predicts at the accepting edge, then loads the next item
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_readings.push_back(fuse_reading(req_digital_raw, req_adc_sample));
            items_accepted++;
         end
         // a stalled item stays put
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               head_sample = pending_samples.pop_front();
               req_valid       <= 1'b1;
               req_digital_raw <= head_sample.digital_raw;
               req_adc_sample  <= head_sample.adc_sample;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: result item with nothing expected: temp %0d src %0b hit %0b",
                        $time, rsp_temperature, rsp_source_is_ntc, rsp_ntc_in_table);
               failures++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_temperature !== want.temperature) begin
                  $display("%0t: temperature expected %0d actual %0d",
                           $time, want.temperature, rsp_temperature);
                  failures++;
               end
               if (rsp_source_is_ntc !== want.source_is_ntc) begin
                  $display("%0t: source_is_ntc expected %0b actual %0b",
                           $time, want.source_is_ntc, rsp_source_is_ntc);
                  failures++;
               end
               if (rsp_ntc_in_table !== want.ntc_in_table) begin
                  $display("%0t: ntc_in_table expected %0b actual %0b",
                           $time, want.ntc_in_table, rsp_ntc_in_table);
                  failures++;
               end
            end
            readings_checked++;
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog: cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d results still due",
                  $time, idle_cycles, expected_readings.size());
         $display("ntc_lookup_and_sensor_fusion_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // both registers at their reset values, written explicitly
      write_csr(CSR_CAL_GAIN, 16'h1000);
      write_csr(CSR_CAL_OFFSET, 16'h0000);

      // field extremes and alternating bit patterns
      add_sample(0, 0);
      add_sample(65535, 4095);
      add_sample(0, 4095);
      add_sample(65535, 0);
      add_sample(16'h5555, 12'hAAA);
      add_sample(16'hAAAA, 12'h555);
      // every fusion branch; averages seen with the source both ways
      add_near(MID_ADC, 129);
      add_near(MID_ADC, 282);
      add_near(MID_ADC, 128);
      add_near(MID_ADC, 300);
      add_near(MID_ADC, 281);
      add_near(MID_ADC, 0);
      add_near(MID_ADC, -64);
      add_near(MID_ADC, -65);
      add_near(MID_ADC, -115);
      add_near(MID_ADC, -116);
      add_near(MID_ADC, -127);
      // exactly half a degree below keeps the digital reading
      add_near(MID_ADC, -128);
      add_near(MID_ADC, -129);
      add_near(MID_ADC, -1);
      // around both ends of the table
      add_sample(1000, 228);
      add_sample(1000, 229);
      add_sample(30000, 3140);
      add_sample(30000, 3141);
      wait_idle();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // calibration setting for this phase, extremes included
         case (phase)
            0: begin
               write_csr(CSR_CAL_GAIN, 16'h1000);
               write_csr(CSR_CAL_OFFSET, 16'h0000);
            end
            1: begin
               write_csr(CSR_CAL_GAIN, 16'h7FFF);
               write_csr(CSR_CAL_OFFSET, 16'h7FFF);
            end
            2: begin
               write_csr(CSR_CAL_GAIN, 16'h8000);
               write_csr(CSR_CAL_OFFSET, 16'h8000);
            end
            3: begin
               write_csr(CSR_CAL_GAIN, 16'h0000);
               write_csr(CSR_CAL_OFFSET, DATA_W'($urandom_range(65535)));
            end
            4: begin
               write_csr(CSR_CAL_GAIN, DATA_W'($urandom_range(65535)));
               write_csr(CSR_CAL_OFFSET, DATA_W'($urandom_range(65535)));
               // index past the register map must change nothing
               write_csr(CSR_IDX_W'($urandom_range(255, 2)), DATA_W'($urandom_range(65535)));
            end
            5: begin
               write_csr(CSR_CAL_GAIN, 16'h1000);
               write_csr(CSR_CAL_OFFSET, 16'h8000);
            end
            6: begin
               write_csr(CSR_CAL_GAIN, 16'hF000);
               write_csr(CSR_CAL_OFFSET, 16'h7FFF);
            end
            default: begin
               write_csr(CSR_CAL_GAIN, DATA_W'($urandom_range(65535)));
               write_csr(CSR_CAL_OFFSET, DATA_W'($urandom_range(65535)));
            end
         endcase

         // flow control: none, sender gaps, receiver stalls, both
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 79;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 79;
            end
            default: begin
               send_idle_pct = 28;
               recv_stall_pct = 28;
            end
         endcase

         add_random_samples(RANDOM_PER_PHASE);
         wait_idle();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run covered %0d items and %0d checked results over %0d calibration settings",
               items_accepted, readings_checked, NUM_PHASES + 1);
      $display("flow control phases: free running, sender gaps, receiver stalls, mixed");
      if (failures == 0) begin
         $display("ntc_lookup_and_sensor_fusion_core: match");
      end else begin
         $display("%0d field mismatches", failures);
         $display("ntc_lookup_and_sensor_fusion_core: mismatch");
      end
      $finish;
   end

endmodule
